// ===== sv/tfbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tfbc_pkg
// Types, constants and round functions of the toy byte-wide Feistel cipher.
// ----------------------------------------------------------------------------
package tfbc_pkg;

    localparam int BYTE_W     = 8;
    localparam int NIB_W      = 4;
    localparam int MODE_W     = 3;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_CIPHER_KEY  = 2'd0,
        REG_INIT_VECTOR = 2'd1,
        REG_CIPHER_MODE = 2'd2
    } reg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ECB_ENC = 3'd0,
        MODE_ECB_DEC = 3'd1,
        MODE_CBC_ENC = 3'd2,
        MODE_CBC_DEC = 3'd3,
        MODE_OFB     = 3'd4
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] cipher_key;
        logic [BYTE_W-1:0] init_vector;
        logic [MODE_W-1:0] cipher_mode;
    } cfg_t;

    typedef struct packed {
        logic              stage_valid;
        logic              advance;
        logic [BYTE_W-1:0] stage_data;
    } stat_t;

    localparam logic [NIB_W-1:0] SBOX [16] = '{
        4'h9, 4'h4, 4'hA, 4'hB,
        4'hD, 4'h1, 4'h8, 4'h5,
        4'h6, 4'h2, 4'h0, 4'h3,
        4'hC, 4'hE, 4'hF, 4'h7
    };

    localparam logic [2:0] BIT_DEST [BYTE_W] = '{
        3'd1, 3'd5, 3'd2, 3'd0, 3'd3, 3'd7, 3'd4, 3'd6
    };

    function automatic logic [NIB_W-1:0] sub_nib(input logic [NIB_W-1:0] x);
        return SBOX[x];
    endfunction

    function automatic logic [BYTE_W-1:0] perm_fwd(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[BIT_DEST[i]] = b[i];
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] perm_inv(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[i] = b[BIT_DEST[i]];
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] blk_enc(input logic [BYTE_W-1:0] b,
                                                  input logic [NIB_W-1:0]  k);
        logic [NIB_W-1:0] lo;
        logic [NIB_W-1:0] ro;
        logic [NIB_W-1:0] nr;
        lo = b[BYTE_W-1:NIB_W];
        ro = b[NIB_W-1:0];
        nr = lo ^ sub_nib(ro ^ k);
        return perm_fwd({ro, nr});
    endfunction

    function automatic logic [BYTE_W-1:0] blk_dec(input logic [BYTE_W-1:0] b,
                                                  input logic [NIB_W-1:0]  k);
        logic [BYTE_W-1:0] c;
        logic [NIB_W-1:0]  lo;
        logic [NIB_W-1:0]  ro;
        c  = perm_inv(b);
        ro = c[BYTE_W-1:NIB_W];
        lo = c[NIB_W-1:0] ^ sub_nib(ro ^ k);
        return {lo, ro};
    endfunction

endpackage

// ===== sv/tfbc_if.sv =====
// ----------------------------------------------------------------------------
// tfbc_in_if / tfbc_out_if
// Valid/ready channels for input bytes and result bytes.
// ----------------------------------------------------------------------------
interface tfbc_in_if
    import tfbc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_in;
    logic              start_of_message;

    modport source (output valid, output data_in, output start_of_message, input ready);
    modport sink   (input valid, input data_in, input start_of_message, output ready);
endinterface

interface tfbc_out_if
    import tfbc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

// ===== sv/tfbc_regs.sv =====
// ----------------------------------------------------------------------------
// tfbc_regs
// APB register file: cipher key, init vector and chaining mode.
// ----------------------------------------------------------------------------
module tfbc_regs
    import tfbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [BYTE_W-1:0] key_reg;
    logic [BYTE_W-1:0] iv_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            iv_reg   <= '0;
            mode_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CIPHER_KEY:  key_reg  <= pwdata[BYTE_W-1:0];
                REG_INIT_VECTOR: iv_reg   <= pwdata[BYTE_W-1:0];
                REG_CIPHER_MODE: mode_reg <= pwdata[MODE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CIPHER_KEY:  prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, key_reg};
            REG_INIT_VECTOR: prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, iv_reg};
            REG_CIPHER_MODE: prdata = {{(CFG_DATA_W-MODE_W){1'b0}}, mode_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.cipher_key  = key_reg;
    assign cfg.init_vector = iv_reg;
    assign cfg.cipher_mode = mode_reg;

endmodule

// ===== sv/tfbc_datapath.sv =====
// ----------------------------------------------------------------------------
// tfbc_datapath
// Input stage, one cipher round with chaining, and the result register.
// ----------------------------------------------------------------------------
module tfbc_datapath
    import tfbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    tfbc_in_if.sink           in_chan,
    tfbc_out_if.source        out_chan,
    output stat_t             stat
);

    logic              stage_valid_reg;
    logic              stage_valid_next;
    logic [BYTE_W-1:0] stage_data_reg;
    logic              stage_start_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_data_reg;
    logic [BYTE_W-1:0] chain_reg;
    logic [BYTE_W-1:0] chain_next;
    logic [BYTE_W-1:0] chain_cur;
    logic [BYTE_W-1:0] result_next;
    logic [BYTE_W-1:0] ofb_word;
    logic [NIB_W-1:0]  key_nib;
    logic              advance;
    logic              in_accept;

    assign advance   = stage_valid_reg && (!out_valid_reg || out_chan.ready);
    assign in_accept = in_chan.valid && in_chan.ready;

    assign in_chan.ready   = !stage_valid_reg || advance;
    assign out_chan.valid  = out_valid_reg;
    assign out_chan.data_out = out_data_reg;

    assign key_nib   = cfg.cipher_key[NIB_W-1:0];
    assign chain_cur = stage_start_reg ? cfg.init_vector : chain_reg;
    assign ofb_word  = blk_enc(chain_cur, key_nib);

    always_comb
    begin
        chain_next  = chain_cur;
        result_next = stage_data_reg;
        case (cfg.cipher_mode)
            MODE_ECB_ENC: result_next = blk_enc(stage_data_reg, key_nib);
            MODE_ECB_DEC: result_next = blk_dec(stage_data_reg, key_nib);
            MODE_CBC_ENC:
            begin
                result_next = blk_enc(stage_data_reg ^ chain_cur, key_nib);
                chain_next  = result_next;
            end
            MODE_CBC_DEC:
            begin
                result_next = blk_dec(stage_data_reg, key_nib) ^ chain_cur;
                chain_next  = stage_data_reg;
            end
            MODE_OFB:
            begin
                chain_next  = ofb_word;
                result_next = stage_data_reg ^ ofb_word;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_accept)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_chan.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            chain_reg       <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (advance)
                chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_data_reg  <= in_chan.data_in;
            stage_start_reg <= in_chan.start_of_message;
        end
        if (advance)
            out_data_reg <= result_next;
    end

    assign stat.stage_valid = stage_valid_reg;
    assign stat.advance     = advance;
    assign stat.stage_data  = stage_data_reg;

endmodule

// ===== sv/toy_feistel_byte_cipher_modes_top.sv =====
// ----------------------------------------------------------------------------
// toy_feistel_byte_cipher_modes_top
// Byte-wide toy Feistel cipher with ECB, CBC and OFB chaining.
// ----------------------------------------------------------------------------
// Usage:
//   Program cipher_key, init_vector and cipher_mode over the APB port while
//   the stream is idle. Send bytes on in_chan; set start_of_message on the
//   first byte of a message to reload the chain register from init_vector.
//   Each input transaction yields exactly one output transaction on out_chan.
// Path: a byte accepted on in_chan is loaded into the input stage register,
//   passes one round into the result register, and leaves on out_chan from
//   there; a stall on out_chan can hold it in either register.
// Throughput: one byte per cycle while out_chan is not stalled; the chain
//   register closes its loop through a single round per byte.
// Reset: rst_n clears the config registers, chain value and both valid flags.
// Stall: while out_chan is held, the result register holds, the input stage
//   keeps one more byte, and in_chan.ready drops once both are full.
// ----------------------------------------------------------------------------
module toy_feistel_byte_cipher_modes_top
    import tfbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    tfbc_in_if.sink               in_chan,
    tfbc_out_if.source            out_chan
);

    cfg_t  cfg;
    stat_t stat;

    tfbc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tfbc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_chan  (in_chan),
        .out_chan (out_chan),
        .stat     (stat)
    );

`ifndef SYNTHESIS
    a_advance_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        stat.advance |=> out_chan.valid)
        else $error("result register not loaded after advance");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_chan.valid && in_chan.ready) |=> stat.stage_valid)
        else $error("input stage empty after accepted transaction");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_chan.ready |-> (stat.stage_valid && out_chan.valid && !out_chan.ready))
        else $error("input stalled while pipeline can move");

    a_unused_mode_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.advance && cfg.cipher_mode != MODE_ECB_ENC
         && cfg.cipher_mode != MODE_ECB_DEC && cfg.cipher_mode != MODE_CBC_ENC
         && cfg.cipher_mode != MODE_CBC_DEC && cfg.cipher_mode != MODE_OFB)
        |=> out_chan.data_out == $past(stat.stage_data))
        else $error("unused mode did not pass data through");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the toy byte cipher with ECB, CBC and OFB chaining.
// ----------------------------------------------------------------------------
// Programs key, IV and mode over APB while the stream is idle, pushes short
// messages of bytes through the valid/ready input channel with random gaps,
// stalls the output channel at random, and compares every result byte
// against an independent model of the round, the bit shuffle and the chaining.
// ----------------------------------------------------------------------------
import tfbc_pkg::*;

class cipher_scoreboard;
    logic [BYTE_W-1:0] key;
    logic [BYTE_W-1:0] iv;
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] chain;
    logic [BYTE_W-1:0] expected_bytes[$];
    int                error_count;

    function new();
        key         = '0;
        iv          = '0;
        mode        = '0;
        chain       = '0;
        error_count = 0;
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        case (addr[CFG_ADDR_W-1:2])
            REG_CIPHER_KEY:  key  = data[BYTE_W-1:0];
            REG_INIT_VECTOR: iv   = data[BYTE_W-1:0];
            REG_CIPHER_MODE: mode = data[MODE_W-1:0];
            default: ;
        endcase
    endfunction

    function logic [NIB_W-1:0] subst(logic [NIB_W-1:0] n);
        case (n)
            4'h0: return 4'h9;
            4'h1: return 4'h4;
            4'h2: return 4'hA;
            4'h3: return 4'hB;
            4'h4: return 4'hD;
            4'h5: return 4'h1;
            4'h6: return 4'h8;
            4'h7: return 4'h5;
            4'h8: return 4'h6;
            4'h9: return 4'h2;
            4'hA: return 4'h0;
            4'hB: return 4'h3;
            4'hC: return 4'hC;
            4'hD: return 4'hE;
            4'hE: return 4'hF;
            default: return 4'h7;
        endcase
    endfunction

    function logic [BYTE_W-1:0] scramble(logic [BYTE_W-1:0] b);
        return {b[5], b[7], b[1], b[6], b[4], b[2], b[0], b[3]};
    endfunction

    function logic [BYTE_W-1:0] unscramble(logic [BYTE_W-1:0] r);
        return {r[6], r[4], r[7], r[3], r[0], r[2], r[5], r[1]};
    endfunction

    function logic [BYTE_W-1:0] encrypt_byte(logic [BYTE_W-1:0] b);
        logic [NIB_W-1:0] left;
        logic [NIB_W-1:0] right;
        left  = b[7:4];
        right = b[3:0];
        return scramble({right, left ^ subst(right ^ key[NIB_W-1:0])});
    endfunction

    function logic [BYTE_W-1:0] decrypt_byte(logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        logic [NIB_W-1:0]  left;
        logic [NIB_W-1:0]  right;
        c     = unscramble(b);
        right = c[7:4];
        left  = c[3:0] ^ subst(right ^ key[NIB_W-1:0]);
        return {left, right};
    endfunction

    function void note_input(logic [BYTE_W-1:0] d, logic som);
        logic [BYTE_W-1:0] res;
        if (som)
            chain = iv;
        case (mode)
            MODE_ECB_ENC: res = encrypt_byte(d);
            MODE_ECB_DEC: res = decrypt_byte(d);
            MODE_CBC_ENC:
            begin
                res   = encrypt_byte(d ^ chain);
                chain = res;
            end
            MODE_CBC_DEC:
            begin
                res   = decrypt_byte(d) ^ chain;
                chain = d;
            end
            MODE_OFB:
            begin
                chain = encrypt_byte(chain);
                res   = d ^ chain;
            end
            default: res = d;
        endcase
        expected_bytes.push_back(res);
    endfunction

    function void check_output(logic [BYTE_W-1:0] actual);
        logic [BYTE_W-1:0] exp_byte;
        if (expected_bytes.size() == 0)
        begin
            $error("data_out: unexpected transaction, expected none, actual %02h", actual);
            error_count++;
            return;
        end
        exp_byte = expected_bytes.pop_front();
        if (actual !== exp_byte)
        begin
            $error("data_out: expected %02h, actual %02h", exp_byte, actual);
            error_count++;
        end
    endfunction
endclass

module tb_top;

    localparam int                    CLK_HALF       = 5;
    localparam int                    RESET_CYCLES   = 9;
    localparam int                    RANDOM_ITEMS   = 1450;
    localparam int                    STALL_LIMIT    = 4000;
    localparam int                    DRAIN_CYCLES   = 4;
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED  = 4'd12;
    localparam logic [MODE_W-1:0]     MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0]     MODE_UNUSED_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    tfbc_in_if  in_if();
    tfbc_out_if out_if();

    cipher_scoreboard sb;
    int               in_profile;
    int               out_profile;
    int               items_sent;
    int               idle_cycles;

    toy_feistel_byte_cipher_modes_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_chan  (in_if),
        .out_chan (out_if)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic int pick_gap(int profile);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (profile == 0)
            return 0;
        if (profile == 1)
        begin
            if (r < 70)
                return 0;
            if (r < 95)
                return $urandom_range(1, 3);
            return $urandom_range(4, 12);
        end
        if (r < 40)
            return 0;
        if (r < 80)
            return $urandom_range(1, 4);
        if (r < 95)
            return $urandom_range(5, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_ADDR_W-1:0] reg_addr(reg_idx_t idx);
        return {idx, 2'b00};
    endfunction

    task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] d, logic som);
        int gap;
        gap = pick_gap(in_profile);
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid            <= 1'b1;
        in_if.data_in          <= d;
        in_if.start_of_message <= som;
        do
            @(posedge clk);
        while (!in_if.ready);
        sb.note_input(d, som);
        items_sent++;
    endtask

    task automatic send_message(int len, bit broken);
        logic som;
        for (int i = 0; i < len; i++)
        begin
            if (broken)
                som = ($urandom_range(0, 7) == 0);
            else
                som = (i == 0);
            send_byte(pick_byte(), som);
        end
    endtask

    task automatic configure_random(bit write_all);
        logic [CFG_DATA_W-1:0] junk;
        logic [BYTE_W-1:0]     key_val;
        logic [MODE_W-1:0]     mode_val;
        int unsigned           r;
        junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom()) : '0;
        r = $urandom_range(0, 99);
        key_val = (r < 15) ? 8'h00 : (r < 30) ? 8'hFF : pick_byte();
        if (write_all || $urandom_range(0, 4) != 0)
            apb_write(reg_addr(REG_CIPHER_KEY), {junk[CFG_DATA_W-1:BYTE_W], key_val});
        if (write_all || $urandom_range(0, 4) != 0)
            apb_write(reg_addr(REG_INIT_VECTOR), {junk[CFG_DATA_W-1:BYTE_W], pick_byte()});
        if ($urandom_range(0, 99) < 88)
            mode_val = MODE_W'($urandom_range(MODE_ECB_ENC, MODE_OFB));
        else
            mode_val = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        if (write_all || $urandom_range(0, 5) != 0)
            apb_write(reg_addr(REG_CIPHER_MODE), {junk[CFG_DATA_W-1:MODE_W], mode_val});
        if ($urandom_range(0, 9) == 0)
            apb_write(ADDR_UNMAPPED, CFG_DATA_W'($urandom()));
    endtask

    initial
    begin
        logic [MODE_W-1:0] dir_modes[6];
        int                phase;
        int                phase_items;
        int                len;

        sb          = new();
        in_profile  = 0;
        out_profile = 0;
        items_sent  = 0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_if.valid            = 1'b0;
        in_if.data_in          = '0;
        in_if.start_of_message = 1'b0;

        dir_modes = '{MODE_ECB_ENC, MODE_ECB_DEC, MODE_CBC_ENC, MODE_CBC_DEC, MODE_OFB,
                      MODE_UNUSED_HI};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        for (int m = 0; m < 6; m++)
        begin
            wait_idle();
            apb_write(reg_addr(REG_CIPHER_KEY), (m % 2 == 0) ? 32'h0000_00FF : 32'h0000_0000);
            apb_write(reg_addr(REG_INIT_VECTOR), (m % 3 == 0) ? 32'h0000_0000 : 32'h0000_00FF);
            apb_write(reg_addr(REG_CIPHER_MODE), {29'd0, dir_modes[m]});
            send_byte(8'h00, 1'b1);
            send_byte(8'hFF, 1'b0);
            send_byte(8'h0F, 1'b1);
            send_byte(8'hF0, 1'b0);
            in_if.valid <= 1'b0;
        end

        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            configure_random(phase == 0);
            in_profile  = (phase % 5 == 1) ? 0 : $urandom_range(0, 2);
            out_profile = (phase % 5 == 1) ? 0 : $urandom_range(0, 2);
            phase_items = $urandom_range(40, 140);
            while (phase_items > 0)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
                send_message(len, $urandom_range(0, 9) == 0);
                phase_items -= len;
            end
            in_if.valid <= 1'b0;
            phase++;
        end

        wait_idle();
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int hold_left;
        hold_left    = 0;
        out_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready)
                sb.check_output(out_if.data_out);
            if (hold_left == 0)
                hold_left = pick_gap(out_profile);
            if (hold_left > 0)
            begin
                out_if.ready <= 1'b0;
                hold_left--;
            end
            else
                out_if.ready <= 1'b1;
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
sv/tfbc_pkg.sv
sv/tfbc_if.sv
sv/tfbc_regs.sv
sv/tfbc_datapath.sv
sv/toy_feistel_byte_cipher_modes_top.sv
tb/tb_top.sv
